### sv/mmpid_pkg.sv
// Shared types and constants for the multi-mode PID controller.
package mmpid_pkg;

	localparam int GAIN_WIDTH      = 24;
	localparam int LIMIT_WIDTH     = 31;
	localparam int DRIVE_WIDTH     = 32;
	localparam int SUM_WIDTH       = 64;
	localparam int CFG_WIDTH       = 31;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int MODE_WIDTH      = 3;

	typedef enum logic [MODE_WIDTH-1:0] {
		MODE_POS    = 3'd0,
		MODE_EXT_D  = 3'd1,
		MODE_POS_FF = 3'd2,
		MODE_INC    = 3'd3,
		MODE_INC_FF = 3'd4
	} mode_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_MODE           = 3'd0,
		CFG_GAIN_P         = 3'd1,
		CFG_GAIN_I         = 3'd2,
		CFG_GAIN_D         = 3'd3,
		CFG_GAIN_FF        = 3'd4,
		CFG_INTEGRAL_LIMIT = 3'd5,
		CFG_OUTPUT_LIMIT   = 3'd6
	} cfg_index_t;

	localparam logic KIND_STEP  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	localparam logic signed [SUM_WIDTH-1:0] DRIVE_MAX = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [SUM_WIDTH-1:0] DRIVE_MIN = 64'shffff_ffff_8000_0000;

	localparam logic signed [DRIVE_WIDTH-1:0] ACC_MAX = 32'sh7fff_ffff;
	localparam logic signed [DRIVE_WIDTH-1:0] ACC_MIN = 32'sh8000_0000;

endpackage

### sv/mmpid_step.sv
// One control step: error terms, gain products, limiting and next controller state.
module mmpid_step #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  mmpid_pkg::mode_t                              mode,
	input  logic signed [mmpid_pkg::GAIN_WIDTH-1:0]       gain_p,
	input  logic signed [mmpid_pkg::GAIN_WIDTH-1:0]       gain_i,
	input  logic signed [mmpid_pkg::GAIN_WIDTH-1:0]       gain_d,
	input  logic signed [mmpid_pkg::GAIN_WIDTH-1:0]       gain_ff,
	input  logic        [mmpid_pkg::LIMIT_WIDTH-1:0]      integral_limit,
	input  logic        [mmpid_pkg::LIMIT_WIDTH-1:0]      output_limit,
	input  logic                                          kind,
	input  logic signed [SAMPLE_WIDTH-1:0]                target,
	input  logic signed [SAMPLE_WIDTH-1:0]                measured,
	input  logic signed [SAMPLE_WIDTH-1:0]                rate,
	input  logic signed [mmpid_pkg::DRIVE_WIDTH-1:0]      error_sum,
	input  logic signed [SAMPLE_WIDTH:0]                  prior_error,
	input  logic signed [SAMPLE_WIDTH:0]                  older_error,
	input  logic signed [mmpid_pkg::DRIVE_WIDTH-1:0]      drive_reg,
	input  logic signed [SAMPLE_WIDTH-1:0]                prior_target,
	output logic signed [mmpid_pkg::DRIVE_WIDTH-1:0]      next_error_sum,
	output logic signed [SAMPLE_WIDTH:0]                  next_prior_error,
	output logic signed [SAMPLE_WIDTH:0]                  next_older_error,
	output logic signed [mmpid_pkg::DRIVE_WIDTH-1:0]      next_drive_reg,
	output logic signed [SAMPLE_WIDTH-1:0]                next_prior_target,
	output logic signed [mmpid_pkg::DRIVE_WIDTH-1:0]      drive,
	output logic                                          limited
);
	import mmpid_pkg::*;

	localparam int EW  = SAMPLE_WIDTH + 1;
	localparam int PPW = GAIN_WIDTH + EW + 1;
	localparam int PIW = GAIN_WIDTH + DRIVE_WIDTH;
	localparam int PDW = GAIN_WIDTH + EW + 2;
	localparam int PFW = GAIN_WIDTH + SAMPLE_WIDTH + 1;

	logic signed [EW-1:0]           err;
	logic signed [DRIVE_WIDTH:0]    sum_wide;
	logic signed [DRIVE_WIDTH-1:0]  error_sum_new;
	logic signed [EW:0]             diff1;
	logic signed [EW+1:0]           diff2;
	logic signed [SAMPLE_WIDTH:0]   target_diff;

	logic positional, use_d, use_f, incremental;

	logic signed [EW:0]             op_p;
	logic signed [DRIVE_WIDTH-1:0]  op_i;
	logic signed [EW+1:0]           op_d;
	logic signed [SAMPLE_WIDTH:0]   op_f;

	logic signed [PPW-1:0] prod_p;
	logic signed [PIW-1:0] prod_i;
	logic signed [PDW-1:0] prod_d;
	logic signed [PFW-1:0] prod_f;

	logic signed [SUM_WIDTH-1:0] term_p, term_i, term_i_lim, term_d, term_f;
	logic signed [SUM_WIDTH-1:0] ilim, olim, base, total, total_sat, total_lim;

	assign err = EW'(target) - EW'(measured);

	// The integral accumulator saturates at 32 bits.
	assign sum_wide = (DRIVE_WIDTH+1)'(error_sum) + (DRIVE_WIDTH+1)'(err);
	always_comb begin
		if (sum_wide[DRIVE_WIDTH] != sum_wide[DRIVE_WIDTH-1]) begin
			error_sum_new = sum_wide[DRIVE_WIDTH] ? ACC_MIN : ACC_MAX;
		end else begin
			error_sum_new = sum_wide[DRIVE_WIDTH-1:0];
		end
	end

	assign diff1       = (EW+1)'(err) - (EW+1)'(prior_error);
	// Second difference: error - 2 * prior + older.
	assign diff2       = (EW+2)'(err) - ((EW+2)'(prior_error) <<< 1) + (EW+2)'(older_error);
	assign target_diff = (SAMPLE_WIDTH+1)'(target) - (SAMPLE_WIDTH+1)'(prior_target);

	always_comb begin
		positional  = 1'b0;
		use_d       = 1'b0;
		use_f       = 1'b0;
		incremental = 1'b0;
		unique case (mode) inside
			MODE_POS, MODE_EXT_D: begin
				positional = 1'b1;
				use_d      = 1'b1;
			end
			MODE_POS_FF: begin
				positional = 1'b1;
				use_d      = 1'b1;
				use_f      = 1'b1;
			end
			MODE_INC: begin
				incremental = 1'b1;
				use_d       = 1'b1;
			end
			MODE_INC_FF: begin
				incremental = 1'b1;
				use_f       = 1'b1;
			end
			default: begin
				positional = 1'b0;
			end
		endcase
	end

	// One multiplier per gain; the operand depends on the form.
	assign op_p = positional ? (EW+1)'(err) : diff1;
	assign op_i = positional ? error_sum_new : DRIVE_WIDTH'(err);
	assign op_d = (mode == MODE_EXT_D) ? (EW+2)'(rate) :
		(mode == MODE_INC) ? diff2 : (EW+2)'(diff1);
	assign op_f = (mode == MODE_INC_FF) ? target_diff : (SAMPLE_WIDTH+1)'(target);

	assign prod_p = gain_p * op_p;
	assign prod_i = gain_i * op_i;
	assign prod_d = gain_d * op_d;
	assign prod_f = gain_ff * op_f;

	// Arithmetic shifts round toward minus infinity.
	assign term_p = SUM_WIDTH'(prod_p >>> GAIN_FRAC_BITS);
	assign term_i = SUM_WIDTH'(prod_i >>> GAIN_FRAC_BITS);
	assign term_d = SUM_WIDTH'(prod_d >>> GAIN_FRAC_BITS);
	assign term_f = SUM_WIDTH'(prod_f >>> GAIN_FRAC_BITS);

	assign ilim = {{(SUM_WIDTH-LIMIT_WIDTH){1'b0}}, integral_limit};
	assign olim = {{(SUM_WIDTH-LIMIT_WIDTH){1'b0}}, output_limit};

	always_comb begin
		term_i_lim = term_i;
		if (positional && ilim != '0) begin
			if (term_i > ilim) begin
				term_i_lim = ilim;
			end else if (term_i < -ilim) begin
				term_i_lim = -ilim;
			end
		end
	end

	assign base  = incremental ? SUM_WIDTH'(drive_reg) : '0;
	assign total = base + term_p + term_i_lim + (use_d ? term_d : '0) + (use_f ? term_f : '0);

	always_comb begin
		if (total > DRIVE_MAX) begin
			total_sat = DRIVE_MAX;
		end else if (total < DRIVE_MIN) begin
			total_sat = DRIVE_MIN;
		end else begin
			total_sat = total;
		end
		total_lim = total_sat;
		if (olim != '0) begin
			if (total_sat > olim) begin
				total_lim = olim;
			end else if (total_sat < -olim) begin
				total_lim = -olim;
			end
		end
	end

	always_comb begin
		next_error_sum    = error_sum;
		next_prior_error  = prior_error;
		next_older_error  = older_error;
		next_drive_reg    = drive_reg;
		next_prior_target = prior_target;
		drive             = drive_reg;
		limited           = 1'b0;
		if (kind == KIND_CLEAR) begin
			next_error_sum    = '0;
			next_prior_error  = '0;
			next_older_error  = '0;
			next_drive_reg    = '0;
			next_prior_target = '0;
			drive             = '0;
		end else begin
			unique case (mode) inside
				MODE_POS, MODE_POS_FF: begin
					next_error_sum   = error_sum_new;
					next_prior_error = err;
					next_drive_reg   = total_lim[DRIVE_WIDTH-1:0];
					drive            = total_lim[DRIVE_WIDTH-1:0];
					limited          = (total_lim != total);
				end
				MODE_EXT_D: begin
					next_error_sum = error_sum_new;
					next_drive_reg = total_lim[DRIVE_WIDTH-1:0];
					drive          = total_lim[DRIVE_WIDTH-1:0];
					limited        = (total_lim != total);
				end
				MODE_INC: begin
					next_older_error = prior_error;
					next_prior_error = err;
					next_drive_reg   = total_lim[DRIVE_WIDTH-1:0];
					drive            = total_lim[DRIVE_WIDTH-1:0];
					limited          = (total_lim != total);
				end
				MODE_INC_FF: begin
					next_prior_error  = err;
					next_prior_target = target;
					next_drive_reg    = total_lim[DRIVE_WIDTH-1:0];
					drive             = total_lim[DRIVE_WIDTH-1:0];
					limited           = (total_lim != total);
				end
				default: begin
					// Unused mode codes leave the state alone and report the held drive.
					limited = 1'b0;
				end
			endcase
		end
	end

endmodule

### sv/multi_mode_pid_controller.sv
// Top level of the multi-mode PID controller: handshakes, configuration and state registers.
//
// Usage: an input word (kind, target, measured, rate) is taken on in_valid while
// in_stall is low; each input word yields exactly one result word (drive, limited)
// on out_valid, taken while out_stall is low. kind selects a control step or a
// clear of all stored state. Configuration goes through cfg_we, cfg_index and
// cfg_data, one register per cycle, and must only be written while no word is in
// flight.
// Path: an accepted word sits in the input register, is computed in a single pass
// and lands in the output register once that register is free or being emptied.
// Throughput: one word per cycle while out_stall holds no waiting result. The controller
// state (integral sum, past errors, last drive) is updated in the same cycle the word
// moves to the output register, so the next word already sees it.
// Stall: while out_stall holds a waiting result, the input register still takes one
// more word; in_stall rises only when both registers are full.
// Reset clears all configuration registers (mode positional, gains and limits zero),
// the controller state and both valid flags.
module multi_mode_pid_controller #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_we,
	input  logic [mmpid_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
	input  logic [mmpid_pkg::CFG_WIDTH-1:0]             cfg_data,
	input  logic                                        in_valid,
	output logic                                        in_stall,
	input  logic                                        kind,
	input  logic signed [SAMPLE_WIDTH-1:0]              target,
	input  logic signed [SAMPLE_WIDTH-1:0]              measured,
	input  logic signed [SAMPLE_WIDTH-1:0]              rate,
	output logic                                        out_valid,
	input  logic                                        out_stall,
	output logic signed [mmpid_pkg::DRIVE_WIDTH-1:0]    drive,
	output logic                                        limited
);
	import mmpid_pkg::*;

	logic [MODE_WIDTH-1:0]         mode_q;
	logic signed [GAIN_WIDTH-1:0]  gain_p_q, gain_i_q, gain_d_q, gain_ff_q;
	logic [LIMIT_WIDTH-1:0]        integral_limit_q, output_limit_q;

	logic                           valid_s1, kind_s1;
	logic signed [SAMPLE_WIDTH-1:0] target_s1, measured_s1, rate_s1;

	logic signed [DRIVE_WIDTH-1:0]  error_sum_q, drive_reg_q;
	logic signed [SAMPLE_WIDTH:0]   prior_error_q, older_error_q;
	logic signed [SAMPLE_WIDTH-1:0] prior_target_q;

	logic signed [DRIVE_WIDTH-1:0]  error_sum_n, drive_reg_n, drive_n;
	logic signed [SAMPLE_WIDTH:0]   prior_error_n, older_error_n;
	logic signed [SAMPLE_WIDTH-1:0] prior_target_n;
	logic                           limited_n;

	logic out_valid_q, out_ready, fire, accept_in;

	assign out_ready = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !out_ready;
	assign accept_in = in_valid && !in_stall;
	assign fire      = valid_s1 && out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= '0;
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			gain_ff_q        <= '0;
			integral_limit_q <= '0;
			output_limit_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_MODE:           mode_q           <= cfg_data[MODE_WIDTH-1:0];
				CFG_GAIN_P:         gain_p_q         <= cfg_data[GAIN_WIDTH-1:0];
				CFG_GAIN_I:         gain_i_q         <= cfg_data[GAIN_WIDTH-1:0];
				CFG_GAIN_D:         gain_d_q         <= cfg_data[GAIN_WIDTH-1:0];
				CFG_GAIN_FF:        gain_ff_q        <= cfg_data[GAIN_WIDTH-1:0];
				CFG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[LIMIT_WIDTH-1:0];
				CFG_OUTPUT_LIMIT:   output_limit_q   <= cfg_data[LIMIT_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_ready) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			kind_s1     <= kind;
			target_s1   <= target;
			measured_s1 <= measured;
			rate_s1     <= rate;
		end
		if (fire) begin
			drive   <= drive_n;
			limited <= limited_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q    <= '0;
			prior_error_q  <= '0;
			older_error_q  <= '0;
			drive_reg_q    <= '0;
			prior_target_q <= '0;
		end else if (fire) begin
			error_sum_q    <= error_sum_n;
			prior_error_q  <= prior_error_n;
			older_error_q  <= older_error_n;
			drive_reg_q    <= drive_reg_n;
			prior_target_q <= prior_target_n;
		end
	end

	mmpid_step #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_step (
		.mode              (mode_t'(mode_q)),
		.gain_p            (gain_p_q),
		.gain_i            (gain_i_q),
		.gain_d            (gain_d_q),
		.gain_ff           (gain_ff_q),
		.integral_limit    (integral_limit_q),
		.output_limit      (output_limit_q),
		.kind              (kind_s1),
		.target            (target_s1),
		.measured          (measured_s1),
		.rate              (rate_s1),
		.error_sum         (error_sum_q),
		.prior_error       (prior_error_q),
		.older_error       (older_error_q),
		.drive_reg         (drive_reg_q),
		.prior_target      (prior_target_q),
		.next_error_sum    (error_sum_n),
		.next_prior_error  (prior_error_n),
		.next_older_error  (older_error_n),
		.next_drive_reg    (drive_reg_n),
		.next_prior_target (prior_target_n),
		.drive             (drive_n),
		.limited           (limited_n)
	);

	// The input side only backs up when both registers hold a word.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while a register was free");

	// A word leaving the input register always shows up as a result.
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("computed word did not reach the output register");

	// The delivered drive always matches the stored drive state.
	a_drive_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (drive == drive_reg_q))
		else $error("result drive differs from stored drive");

	// A clear word zeroes the state and reports a zero, unlimited drive.
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && kind_s1 == KIND_CLEAR) |=>
		(drive == '0 && !limited && error_sum_q == '0 && prior_error_q == '0))
		else $error("clear word left state or result nonzero");

endmodule
